/* hdl/spsag_pkg.sv */
`timescale 1ns / 1ps

package spsag_pkg;

  localparam int unsigned DIM_W     = 7;
  localparam int unsigned BOUND_W   = 9;
  localparam int unsigned COORD_W   = 6;
  localparam int unsigned SEQ_W     = 13;
  localparam int unsigned RES_W     = 4;
  // Any side reaches the right-moving side within four openings, and that side
  // always places a cell or ends the walk.
  localparam int unsigned SETTLE_N  = 4;

  localparam logic [DIM_W-1:0] MaxDim    = 7'd64;
  localparam logic [DIM_W-1:0] ResetDim  = 7'd8;
  localparam logic [RES_W-1:0] ResidueTop = 4'd10;  // residue modulo 11 wraps past this

  localparam logic [0:0] REG_GRID_ROWS = 1'b0;
  localparam logic [0:0] REG_GRID_COLS = 1'b1;

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_UP    = 2'd3
  } dir_e;

  typedef struct packed {
    logic signed [BOUND_W-1:0] top;
    logic signed [BOUND_W-1:0] left;
    logic signed [BOUND_W-1:0] bottom;
    logic signed [BOUND_W-1:0] right;
    logic signed [BOUND_W-1:0] idx;
    dir_e                      dir;
    logic [SEQ_W-1:0]          seq;
    logic [RES_W-1:0]          residue;
    logic                      fin;
  } walk_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [SEQ_W-1:0]   seq_value;
    logic               eleven_multiple;
    logic               last_cell;
    logic               done_res;
  } res_t;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v);
    return (v > MaxDim) ? MaxDim : v;
  endfunction

  // Fresh walk: first cell is the top-left corner, empty grid is done at once.
  function automatic walk_t load_walk(logic [DIM_W-1:0] rows, logic [DIM_W-1:0] cols);
    walk_t w;
    w.top     = '0;
    w.left    = '0;
    w.bottom  = $signed({2'b00, clamp_dim(rows)});
    w.right   = $signed({2'b00, clamp_dim(cols)});
    w.idx     = '0;
    w.dir     = DIR_RIGHT;
    w.seq     = SEQ_W'(1);
    w.residue = RES_W'(1);
    w.fin     = (rows == '0) || (cols == '0);
    return w;
  endfunction

endpackage

/* hdl/spsag_step.sv */
`timescale 1ns / 1ps

module spsag_step (
  input  spsag_pkg::walk_t       state_i,
  input  logic                   restart_i,
  input  logic [spsag_pkg::DIM_W-1:0] rows_i,
  input  logic [spsag_pkg::DIM_W-1:0] cols_i,
  output spsag_pkg::walk_t       state_o,
  output spsag_pkg::res_t        res_o
);
  import spsag_pkg::*;

  function automatic dir_e next_dir(dir_e d);
    case (d)
      DIR_RIGHT: return DIR_DOWN;
      DIR_DOWN:  return DIR_LEFT;
      DIR_LEFT:  return DIR_UP;
      default:   return DIR_RIGHT;
    endcase
  endfunction

  // Open sides until one holds a cell or the walk ends; empty sides shrink a bound and pass on.
  function automatic walk_t settle(walk_t w_in);
    walk_t w;
    logic  placed;
    w      = w_in;
    placed = 1'b0;
    for (int g = 0; g < SETTLE_N; g++) begin
      if (!placed) begin
        case (w.dir)
          DIR_RIGHT: begin
            if (!(w.top < w.bottom && w.left < w.right)) begin
              w.fin = 1'b1;
            end else begin
              w.idx = w.left;
            end
            placed = 1'b1;
          end
          DIR_DOWN: begin
            if (w.top < w.bottom) begin
              w.idx  = w.top;
              placed = 1'b1;
            end else begin
              w.right = w.right - 9'sd1;
              w.dir   = next_dir(w.dir);
            end
          end
          DIR_LEFT: begin
            if (w.top < w.bottom && w.left < w.right) begin
              w.idx  = w.right - 9'sd1;
              placed = 1'b1;
            end else begin
              if (w.top < w.bottom) w.bottom = w.bottom - 9'sd1;
              w.dir = next_dir(w.dir);
            end
          end
          default: begin
            if (w.left < w.right && w.top < w.bottom) begin
              w.idx  = w.bottom - 9'sd1;
              placed = 1'b1;
            end else begin
              if (w.left < w.right) w.left = w.left + 9'sd1;
              w.dir = next_dir(w.dir);
            end
          end
        endcase
      end
    end
    if (!placed) w.fin = 1'b1;
    return w;
  endfunction

  walk_t cur;
  walk_t nxt;
  walk_t closed;
  logic  step_on;

  always_comb begin
    cur = restart_i ? load_walk(rows_i, cols_i) : state_i;

    case (cur.dir)
      DIR_RIGHT: step_on = (cur.idx + 9'sd1) < cur.right;
      DIR_DOWN:  step_on = (cur.idx + 9'sd1) < cur.bottom;
      DIR_LEFT:  step_on = cur.idx > cur.left;
      default:   step_on = cur.idx > cur.top;
    endcase

    // Close the side: shrink its bound, turn, and find the next cell.
    closed = cur;
    case (cur.dir)
      DIR_RIGHT: closed.top    = cur.top + 9'sd1;
      DIR_DOWN:  closed.right  = cur.right - 9'sd1;
      DIR_LEFT:  closed.bottom = cur.bottom - 9'sd1;
      default:   closed.left   = cur.left + 9'sd1;
    endcase
    closed.dir = next_dir(cur.dir);
    closed     = settle(closed);

    if (step_on) begin
      nxt = cur;
      if (cur.dir == DIR_RIGHT || cur.dir == DIR_DOWN) begin
        nxt.idx = cur.idx + 9'sd1;
      end else begin
        nxt.idx = cur.idx - 9'sd1;
      end
    end else begin
      nxt = closed;
    end
    nxt.seq     = cur.seq + SEQ_W'(1);
    nxt.residue = (cur.residue >= ResidueTop) ? '0 : cur.residue + RES_W'(1);

    res_o = '0;
    if (cur.fin) begin
      state_o       = cur;
      res_o.done_res = 1'b1;
    end else begin
      state_o = nxt;
      case (cur.dir)
        DIR_RIGHT: begin
          res_o.row = cur.top[COORD_W-1:0];
          res_o.col = cur.idx[COORD_W-1:0];
        end
        DIR_DOWN: begin
          res_o.row = cur.idx[COORD_W-1:0];
          res_o.col = 6'(cur.right - 9'sd1);
        end
        DIR_LEFT: begin
          res_o.row = 6'(cur.bottom - 9'sd1);
          res_o.col = cur.idx[COORD_W-1:0];
        end
        default: begin
          res_o.row = cur.idx[COORD_W-1:0];
          res_o.col = cur.left[COORD_W-1:0];
        end
      endcase
      res_o.seq_value       = cur.seq;
      res_o.eleven_multiple = (cur.residue == '0);
      res_o.last_cell       = nxt.fin;
    end
  end

endmodule

/* hdl/spiral_scan_address_generator_core.sv */
`timescale 1ns / 1ps
// Spiral scan address generator: clockwise spiral order over a grid.
// Slave stream: one beat per tick, s_axis_tdata[0] = restart (restart the
//   walk and emit the first cell), otherwise emit the current cell and advance.
// Master stream: one beat per accepted tick. tdata carries row, col, the
//   1-based sequence number and the multiple-of-11 flag; tlast marks the
//   final cell; tuser[0] marks done (no cell left, all data zero).
// Configuration: cfg_we_i writes grid_rows (index 0) or grid_cols (index 1);
//   every write restarts the walk. Write only while the stream is idle.
// The result beat is registered and appears in the cycle after the tick is accepted.
// Flow: one beat per cycle while not stalled; the walk state updates in one pass
//   through the step logic, including the turn onto the next non-empty side.
// Stall: the result register holds while m_axis_tready is low; s_axis_tready
//   stays high as long as that register is empty or being drained.
// Reset: both dimensions return to 8 and the walk rests at the first cell.
module spiral_scan_address_generator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [5:0] row, [11:6] col, [24:12] seq_value,
                                      // [25] eleven_multiple, [31:26] zero
  output logic        m_axis_tlast,   // last_cell
  output logic [0:0]  m_axis_tuser,   // [0] done_res
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [6:0]  cfg_data_i
);
  import spsag_pkg::*;

  logic [DIM_W-1:0] rows_q, rows_d;
  logic [DIM_W-1:0] cols_q, cols_d;
  walk_t            walk_q, walk_d;
  walk_t            walk_step;
  res_t             res_step;
  res_t             out_q;
  logic             out_valid_q;
  logic             in_beat;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  spsag_step u_step (
    .state_i   (walk_q),
    .restart_i (s_axis_tdata[0]),
    .rows_i    (rows_q),
    .cols_i    (cols_q),
    .state_o   (walk_step),
    .res_o     (res_step)
  );

  // Register write: take the new dimension and reload the walk from it.
  always_comb begin
    rows_d = rows_q;
    cols_d = cols_q;
    walk_d = walk_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GRID_ROWS: rows_d = cfg_data_i;
        default:       cols_d = cfg_data_i;
      endcase
      walk_d = load_walk(rows_d, cols_d);
    end else if (in_beat) begin
      walk_d = walk_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q      <= ResetDim;
      cols_q      <= ResetDim;
      walk_q      <= load_walk(ResetDim, ResetDim);
      out_valid_q <= 1'b0;
    end else begin
      rows_q <= rows_d;
      cols_q <= cols_d;
      walk_q <= walk_d;
      if (in_beat) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register: load on every accepted tick, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_beat) out_q <= res_step;
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = {6'd0, out_q.eleven_multiple, out_q.seq_value, out_q.col, out_q.row};
  assign m_axis_tlast    = out_q.last_cell;
  assign m_axis_tuser[0] = out_q.done_res;

endmodule

/* hdl/spsag_checker.sv */
`timescale 1ns / 1ps

module spsag_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic [0:0]  m_axis_tuser
);

  // A stalled result beat holds.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // An empty result register never blocks the input.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty result register");

  // A done beat carries no cell.
  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 32'd0 && !m_axis_tlast)
    else $error("done beat carries cell data");

  // A cell beat has a nonzero sequence number.
  a_seq_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[24:12] != 13'd0)
    else $error("cell beat with zero sequence number");

  // Every accepted tick yields a result beat in the next cycle.
  a_beat_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted tick produced no result beat");

endmodule

bind spiral_scan_address_generator_core spsag_checker u_spsag_checker (.*);
